FILE: rtl/running_kth_smallest_manhattan_assert.svh
// Assertion macros for the running k-th smallest distance block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef RUNNING_KTH_SMALLEST_MANHATTAN_ASSERT_SVH
`define RUNNING_KTH_SMALLEST_MANHATTAN_ASSERT_SVH
// Check a property on every clock edge outside reset.
`define RKSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define RKSM_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/rksm_pkg.sv
// Shared constants for the running k-th smallest distance block.
// No dependencies.
package rksm_pkg;
    localparam int MAX_RANK_DEF = 1024;
    localparam int DIST_W       = 33;
    localparam int COORD_W      = 32;
    localparam int RANK_W       = 11;
endpackage

FILE: rtl/rksm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rksm_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/running_kth_smallest_manhattan.sv
// Each accepted distance goes into the ascending store: entries are read and compared
// from the top down, each above it shifted down one slot, and it is written where the
// scan stops (slot 0 by a separate write); slot k-1 is then read if at least k entries
// are stored. One transaction at a time: in_ready is high only in idle, re-entered as
// the result enters the output register, so a stalled output holds the block. Reset
// (rst_n, async low): empty store, rank 1, no result pending; RAM is not cleared.
module running_kth_smallest_manhattan
    import rksm_pkg::*;
#(
    parameter int MAX_RANK = MAX_RANK_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rank_k_we,
    input  logic [RANK_W-1:0]   rank_k_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [COORD_W-1:0] x_coord,
    input  logic signed [COORD_W-1:0] y_coord,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COORD_W-1:0]  kth_distance,
    output logic                have_k
);
    `include "running_kth_smallest_manhattan_assert.svh"

    localparam int AW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int CW = $clog2(MAX_RANK + 1);
    localparam int KW = (CW > RANK_W) ? CW : RANK_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_RANK - 1);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_RANK);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_CMP   = 7'b0000100,
        ST_WR0   = 7'b0001000,
        ST_RDK   = 7'b0010000,
        ST_WAITK = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [RANK_W-1:0]   rank_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [COORD_W-1:0]  res_dist_reg, res_dist_next;
    logic                res_have_reg, res_have_next;
    logic                out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]  out_dist_reg, out_dist_next;
    logic                out_have_reg, out_have_next;

    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [DIST_W-1:0]   wdata, rdata;

    logic [COORD_W-1:0]  mag_x, mag_y;
    logic [DIST_W-1:0]   new_dist;
    logic [CW-1:0]       n_start;
    logic [KW-1:0]       k_eff;
    logic                accept;

    rksm_ram #(.WIDTH(DIST_W), .DEPTH(MAX_RANK), .AW(AW)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign mag_x    = x_coord[COORD_W-1] ? (~x_coord + 1'b1) : x_coord;
    assign mag_y    = y_coord[COORD_W-1] ? (~y_coord + 1'b1) : y_coord;
    assign new_dist = {1'b0, mag_x} + {1'b0, mag_y};
    assign n_start  = restart ? '0 : count_reg;

    always_comb
    begin
        k_eff = KW'(rank_reg);
        if (k_eff == '0)
        begin
            k_eff = KW'(1);
        end
        if (k_eff > KW'(MAX_RANK))
        begin
            k_eff = KW'(MAX_RANK);
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign kth_distance = out_dist_reg;
    assign have_k       = out_have_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        dist_next      = dist_reg;
        res_dist_next  = res_dist_reg;
        res_have_next  = res_have_reg;
        out_valid_next = out_valid_reg;
        out_dist_next  = out_dist_reg;
        out_have_next  = out_have_reg;
        we             = 1'b0;
        waddr          = idx_reg;
        wdata          = dist_reg;
        raddr          = idx_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dist_next  = new_dist;
                    count_next = (n_start == MAX_CNT) ? n_start : n_start + 1'b1;
                    if (n_start == '0)
                    begin
                        we         = 1'b1;
                        waddr      = '0;
                        wdata      = new_dist;
                        state_next = ST_RDK;
                    end
                    else
                    begin
                        idx_next   = AW'(n_start - 1'b1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (rdata > dist_reg)
                begin
                    // shift the larger entry down one slot; drop it off the end
                    if (idx_reg != LAST_IDX)
                    begin
                        we    = 1'b1;
                        waddr = idx_reg + 1'b1;
                        wdata = rdata;
                    end
                    if (idx_reg == '0)
                    begin
                        state_next = ST_WR0;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    if (idx_reg != LAST_IDX)
                    begin
                        we    = 1'b1;
                        waddr = idx_reg + 1'b1;
                        wdata = dist_reg;
                    end
                    state_next = ST_RDK;
                end
            end
            ST_WR0:
            begin
                // place the new distance at the head after the last shift
                we         = 1'b1;
                waddr      = '0;
                wdata      = dist_reg;
                state_next = ST_RDK;
            end
            ST_RDK:
            begin
                raddr = AW'(k_eff - 1'b1);
                if (KW'(count_reg) >= k_eff)
                begin
                    state_next = ST_WAITK;
                end
                else
                begin
                    res_dist_next = '0;
                    res_have_next = 1'b0;
                    state_next    = ST_DONE;
                end
            end
            ST_WAITK:
            begin
                res_dist_next = rdata[DIST_W-1] ? '1 : rdata[COORD_W-1:0];
                res_have_next = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_dist_next  = res_dist_reg;
                    out_have_next  = res_have_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rank_reg      <= RANK_W'(1);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (rank_k_we)
            begin
                rank_reg <= rank_k_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        dist_reg     <= dist_next;
        res_dist_reg <= res_dist_next;
        res_have_reg <= res_have_next;
        out_dist_reg <= out_dist_next;
        out_have_reg <= out_have_next;
    end

    `RKSM_ASSERT(a_count_bound, count_reg <= MAX_CNT, "stored count above capacity")
    `RKSM_ASSERT_NEXT(a_accept_busy, accept, state_reg != ST_IDLE,
        "block idle right after a transaction")
    `RKSM_ASSERT(a_have_nonzero, !(out_valid && !have_k) || kth_distance == '0,
        "distance nonzero without k entries")
endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for running_kth_smallest_manhattan.
// Needs rtl/rksm_pkg.sv and the top level; predicts each result from its own sorted store.
module tb_top;
    import rksm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RANK = MAX_RANK_DEF;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      rs;
    } point_t;

    typedef struct {
        logic [COORD_W-1:0] kth_val;
        logic               hk;
    } kth_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      rank_k_we = 1'b0;
    logic [RANK_W-1:0]         rank_k_wdata = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] x_coord = '0;
    logic signed [COORD_W-1:0] y_coord = '0;
    logic                      restart = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [COORD_W-1:0]        kth_distance;
    logic                      have_k;

    point_t             point_q[$];
    kth_result_t        kth_expect_q[$];
    logic [DIST_W-1:0]  nearest_q[$];
    logic [RANK_W-1:0]  model_rank = 11'd1;
    int                 mismatches = 0;
    int                 cycles = 0;
    int                 burst_left = 4;
    int                 gap_left = 0;
    int                 stall_mode = 0;
    int                 stall_cnt = 0;

    running_kth_smallest_manhattan #(.MAX_RANK(MAX_RANK)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .rank_k_we    (rank_k_we),
        .rank_k_wdata (rank_k_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kth_distance (kth_distance),
        .have_k       (have_k)
    );

    always #5 clk = ~clk;

    function automatic logic [DIST_W-1:0] abs_coord(logic signed [COORD_W-1:0] c);
        logic [COORD_W-1:0] m;
        m = c[COORD_W-1] ? (~c + 32'd1) : c;
        return {1'b0, m};
    endfunction

    // Insert the new distance into the ascending store and form the k-th result.
    function automatic kth_result_t predict_kth(point_t p);
        logic [DIST_W-1:0] d;
        int                pos;
        int                k;
        kth_result_t       r;
        if (p.rs)
            nearest_q.delete();
        d = abs_coord(p.x) + abs_coord(p.y);
        pos = 0;
        while (pos < nearest_q.size() && nearest_q[pos] <= d)
            pos++;
        if (pos < MAX_RANK)
        begin
            nearest_q.insert(pos, d);
            if (nearest_q.size() > MAX_RANK)
                void'(nearest_q.pop_back());
        end
        k = (model_rank == 0) ? 1 : (model_rank > MAX_RANK) ? MAX_RANK : model_rank;
        if (nearest_q.size() >= k)
        begin
            r.kth_val = nearest_q[k-1][DIST_W-1] ? 32'hFFFF_FFFF
                                                 : nearest_q[k-1][COORD_W-1:0];
            r.hk = 1'b1;
        end
        else
        begin
            r.kth_val = '0;
            r.hk = 1'b0;
        end
        return r;
    endfunction

    // Driver: bursts of transactions separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                kth_expect_q.insert(kth_expect_q.size(),
                                    predict_kth('{x_coord, y_coord, restart}));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || point_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    point_t p;
                    p = point_q.pop_front();
                    x_coord <= p.x;
                    y_coord <= p.y;
                    restart <= p.rs;
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Monitor: checks results in order; out_ready follows one of three stall modes chosen at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (kth_expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kth_distance=%0d have_k=%0b",
                                 kth_distance, have_k);
                end
                else
                begin
                    kth_result_t e;
                    e = kth_expect_q.pop_front();
                    if (e.kth_val !== kth_distance || e.hk !== have_k)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected dist=%0d have_k=%0b,",
                                      " got dist=%0d have_k=%0b"},
                                     e.kth_val, e.hk, kth_distance, have_k);
                    end
                end
            end
            stall_cnt++;
            if (stall_cnt % 300 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= (stall_cnt % 7) != 3 && (stall_cnt % 7) != 4;
                default: out_ready <= $urandom_range(0, 1);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[running_kth_smallest_manhattan] ERROR");
            $finish;
        end
    end

    task automatic write_rank(logic [RANK_W-1:0] v);
        @(posedge clk);
        rank_k_we <= 1'b1;
        rank_k_wdata <= v;
        model_rank = v;
        @(posedge clk);
        rank_k_we <= 1'b0;
    endtask

    // Sample away from the active edge so driver updates have settled.
    task automatic drain();
        while (point_q.size() != 0 || in_valid || kth_expect_q.size() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic add_point(int x, int y, bit rs);
        point_q.insert(point_q.size(), '{x, y, rs});
    endtask

    // Mostly short streams between restarts keep the shift scan cheap.
    task automatic add_random(int n, int restart_odds);
        point_t p;
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    p.x = $urandom_range(0, 40) - 20;
                    p.y = $urandom_range(0, 40) - 20;
                end
                1:
                begin
                    p.x = $urandom_range(0, 2000) - 1000;
                    p.y = $urandom_range(0, 9);
                end
                default:
                begin
                    p.x = $urandom;
                    p.y = $urandom;
                end
            endcase
            p.rs = ($urandom_range(1, restart_odds) == 1);
            point_q.insert(point_q.size(), p);
        end
    endtask

    localparam int MOST_NEG = 32'sh8000_0000;
    localparam int MOST_POS = 32'sh7FFF_FFFF;

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Rank zero acts as the nearest; extremes, ties and saturation.
        write_rank(11'd0);
        add_point(0, 0, 1'b1);
        add_point(MOST_POS, MOST_POS, 1'b1);
        add_point(MOST_NEG, MOST_NEG, 1'b1);
        add_point(MOST_NEG, 0, 1'b0);
        add_point(0, MOST_NEG, 1'b1);
        add_point(-1, -1, 1'b1);
        add_point(1, 1, 1'b0);
        add_point(2, 0, 1'b0);
        add_point(-5, 3, 1'b1);
        drain();
        write_rank(11'd2);
        add_point(MOST_NEG, MOST_NEG, 1'b1);
        add_point(MOST_NEG, MOST_NEG, 1'b0);
        add_point(7, 7, 1'b0);
        add_point(-7, 7, 1'b0);
        add_point(MOST_POS, -1, 1'b1);
        add_point(3, 3, 1'b0);
        drain();

        write_rank(11'd3);
        add_random(300, 16);
        drain();

        // Fill past capacity with rising distances, then insert into a full store.
        write_rank(11'd2047);
        for (int i = 0; i < MAX_RANK + 6; i++)
            add_point(i * 1000, i % 3, i == 0);
        add_point(5, 5, 1'b0);
        add_point(MOST_POS, MOST_POS, 1'b0);
        add_point(1023 * 1000, 0, 1'b0);
        drain();
        write_rank(11'd1024);
        add_random(20, 1000);
        drain();

        write_rank(11'd1);
        add_random(300, 16);
        drain();
        write_rank(11'($urandom_range(1, 40)));
        add_random(200, 12);
        drain();
        write_rank(11'($urandom_range(1, 8)));
        add_random(200, 20);
        drain();

        if (mismatches == 0)
            $display("[running_kth_smallest_manhattan] OK");
        else
            $display("[running_kth_smallest_manhattan] ERROR");
        $finish;
    end
endmodule

FILE: running_kth_smallest_manhattan.f
+incdir+rtl
rtl/rksm_pkg.sv
rtl/rksm_ram.sv
rtl/running_kth_smallest_manhattan.sv
tb/tb_top.sv
